FILE: rtl/joint_torque_frame_clamp_core_macros.svh
// ----------------------------------------------------------------------------
// joint_torque_frame_clamp_core assertion macros
// Shorthand for the clocked implication checks of the joint torque clamp.
// ----------------------------------------------------------------------------
`ifndef JOINT_TORQUE_FRAME_CLAMP_CORE_MACROS_SVH
`define JOINT_TORQUE_FRAME_CLAMP_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define JTFC_ASSERT_IMP(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication.
`define JTFC_ASSERT_NXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

FILE: rtl/jtfc_pkg.sv
// ----------------------------------------------------------------------------
// jtfc_pkg
// Shared types, constants and small tables of the joint torque frame clamp.
// ----------------------------------------------------------------------------
package jtfc_pkg;

   localparam int TORQUE_BITS_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int BONE_BITS_DEF      = 24;

   localparam int VEC_W   = 16;
   localparam int COEF_W  = 16;
   localparam int ROW_W   = 48;
   localparam int LIMIT_W = 15;
   localparam int FUNC_W  = 2;
   localparam int CSR_IDX_W = 2;

   // The world request saturates to this width before the rotation.
   localparam int REQ_W  = 47;
   localparam int PROD_W = REQ_W + COEF_W;
   localparam int ACC_W  = PROD_W + 1;

   localparam int AXES      = 3;
   localparam int AXIS_W    = 2;
   localparam int CNT_W     = 4;
   localparam int MAC_TERMS = AXES * AXES;
   localparam int MAC_LAT   = 2;
   localparam int MAC_END   = MAC_TERMS + MAC_LAT - 1;
   localparam int AXIS_END  = AXES - 1;

   localparam logic [ROW_W-1:0]   ROW0_RESET  = 48'd16384;
   localparam logic [ROW_W-1:0]   ROW1_RESET  = 48'd1073741824;
   localparam logic [ROW_W-1:0]   ROW2_RESET  = 48'd70368744177664;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32767;

   localparam logic [FUNC_W-1:0] FUNC_WORLD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOCAL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_BONE_A = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_BONE_B = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TWO  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OLD,
      ST_REQ,
      ST_LOCAL,
      ST_FWD,
      ST_NEW,
      ST_UPD,
      ST_OUT
   } jtfc_state_type;

   typedef struct packed {
      jtfc_state_type    state;
      logic [CNT_W-1:0]  cnt;
      logic              issue_valid;
      logic              issue_first;
      logic              issue_last;
      logic [AXIS_W-1:0] issue_axis;
      logic [AXIS_W-1:0] issue_term;
   } jtfc_ctrl_type;

   typedef struct packed {
      logic start;
      logic func_local;
      logic pass_req;
      logic out_free;
   } jtfc_stat_type;

   typedef struct packed {
      logic                     valid;
      logic                     first;
      logic                     last;
      logic [AXIS_W-1:0]        axis;
      logic signed [REQ_W-1:0]  a;
      logic signed [COEF_W-1:0] b;
   } jtfc_mac_op_type;

   typedef struct packed {
      logic                    valid;
      logic [AXIS_W-1:0]       axis;
      logic signed [ACC_W-1:0] acc;
   } jtfc_mac_res_type;

   // Output axis of a matrix term; three terms per axis.
   function automatic logic [AXIS_W-1:0] axis_of(input logic [CNT_W-1:0] c);
      logic [AXIS_W-1:0] r;
      case (c)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         4'd6, 4'd7, 4'd8: r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [AXIS_W-1:0] term_of(input logic [CNT_W-1:0] c);
      logic [AXIS_W-1:0] r;
      case (c)
         4'd0, 4'd3, 4'd6: r = 2'd0;
         4'd1, 4'd4, 4'd7: r = 2'd1;
         4'd2, 4'd5, 4'd8: r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

   // Column coefficient of one packed matrix row, x in the low bits.
   function automatic logic signed [COEF_W-1:0] coef_pick(input logic [ROW_W-1:0] row,
                                                          input logic [AXIS_W-1:0] col);
      logic signed [COEF_W-1:0] r;
      case (col)
         2'd0:    r = row[COEF_W-1:0];
         2'd1:    r = row[2*COEF_W-1:COEF_W];
         2'd2:    r = row[3*COEF_W-1:2*COEF_W];
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/joint_torque_frame_clamp_core.sv
// ----------------------------------------------------------------------------
// joint_torque_frame_clamp_core
// Joint torque controller between two bones: rotates the request into the
// joint frame, clamps each axis and tracks the world torque and bone totals.
// ----------------------------------------------------------------------------
// One item is handled at a time on a single shared multiply-accumulate unit.
// Every matrix product is nine multiplies issued one per cycle, then the
// product and accumulator registers of the unit. A local request (func 1) and
// a world or bone request that needs no clamping both take two matrix products,
// and a clamped world or bone request takes three, because the actual world
// torque then needs a third matrix product. The finished result waits in an
// output register, so the next item is accepted while it is still unread; a
// result finished while the previous one is still unread holds the block in
// its last step until the output register frees up.
// Configuration writes are always accepted.
module joint_torque_frame_clamp_core
   import jtfc_pkg::*;
#(
   parameter int TORQUE_BITS    = TORQUE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   parameter int BONE_BITS      = BONE_BITS_DEF,
   localparam int RSP_W         = 9 * TORQUE_BITS + 9,
   localparam int RSP_TDATA_W   = ((RSP_W + 7) / 8) * 8
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // vec_x, vec_y, vec_z
   input  logic [3*VEC_W-1:0]     req_tdata,
   // func
   input  logic [FUNC_W-1:0]      req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // joint_x, joint_y, joint_z, world_x, world_y, world_z,
   // change_x, change_y, change_z, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // clamped
   output logic                   rsp_tuser,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [ROW_W-1:0]       csr_data
);

`include "joint_torque_frame_clamp_core_macros.svh"

   localparam int T      = TORQUE_BITS;
   localparam int B      = BONE_BITS;
   localparam int SUM_W  = ((B > T + 1) ? B : T + 1) + 2;
   localparam int RSAT_W = (SUM_W > REQ_W) ? SUM_W : REQ_W;
   localparam int UPD_W  = ((B > T + 2) ? B : T + 2) + 1;

   localparam logic signed [RSAT_W-1:0] REQ_HI =
      {{(RSAT_W-REQ_W+1){1'b0}}, {(REQ_W-1){1'b1}}};
   localparam logic signed [RSAT_W-1:0] REQ_LO =
      {{(RSAT_W-REQ_W+1){1'b1}}, {(REQ_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] WLD_HI = {{(ACC_W-T){1'b0}}, {T{1'b1}}};
   localparam logic signed [ACC_W-1:0] WLD_LO = {{(ACC_W-T){1'b1}}, {T{1'b0}}};
   localparam logic signed [REQ_W-1:0] PAS_HI = {{(REQ_W-T){1'b0}}, {T{1'b1}}};
   localparam logic signed [REQ_W-1:0] PAS_LO = {{(REQ_W-T){1'b1}}, {T{1'b0}}};
   localparam logic signed [UPD_W-1:0] BON_HI = {{(UPD_W-B+1){1'b0}}, {(B-1){1'b1}}};
   localparam logic signed [UPD_W-1:0] BON_LO = {{(UPD_W-B+1){1'b1}}, {(B-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] TMAX   = {{(ACC_W-T+1){1'b0}}, {(T-1){1'b1}}};

   // Configuration and persistent state.
   logic [ROW_W-1:0]         row_ff [AXES];
   logic [ROW_W-1:0]         row_in [AXES];
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic signed [T-1:0]      joint_ff [AXES];
   logic signed [T-1:0]      joint_in [AXES];
   logic signed [T:0]        world_ff [AXES];
   logic signed [T:0]        world_in [AXES];
   logic signed [B-1:0]      bone_a_ff [AXES];
   logic signed [B-1:0]      bone_a_in [AXES];
   logic signed [B-1:0]      bone_b_ff [AXES];
   logic signed [B-1:0]      bone_b_in [AXES];

   // Per-item working registers.
   logic [FUNC_W-1:0]        func_ff, func_in;
   logic signed [VEC_W-1:0]  vec_ff [AXES];
   logic signed [VEC_W-1:0]  vec_in [AXES];
   logic signed [REQ_W-1:0]  reqv_ff [AXES];
   logic signed [REQ_W-1:0]  reqv_in [AXES];
   logic signed [T-1:0]      jnew_ff [AXES];
   logic signed [T-1:0]      jnew_in [AXES];
   logic signed [T:0]        oldw_ff [AXES];
   logic signed [T:0]        oldw_in [AXES];
   logic signed [T:0]        neww_ff [AXES];
   logic signed [T:0]        neww_in [AXES];
   logic signed [T+1:0]      change_ff [AXES];
   logic signed [T+1:0]      change_in [AXES];
   logic                     clamped_ff, clamped_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;

   jtfc_ctrl_type            ctrl;
   jtfc_stat_type            stat;
   jtfc_mac_op_type          mac_op;
   jtfc_mac_res_type         mac_res;

   logic [AXIS_W-1:0]        k;
   logic [AXIS_W-1:0]        coef_row, coef_col;
   logic signed [ACC_W-1:0]  rnd_sum, rnd_val;
   logic signed [T:0]        wld_val;
   logic signed [ACC_W-1:0]  lim_ext, lim_val, clamp_src, clamp_res;
   logic                     hit_hi, hit_lo, clamp_ev;
   logic [AXIS_W-1:0]        clamp_axis;
   logic signed [SUM_W-1:0]  s_vec, s_wld, s_bone_a, s_bone_b, s_req;
   logic signed [RSAT_W-1:0] s_req_ext;
   logic signed [REQ_W-1:0]  req_sat;
   logic                     pass;
   logic signed [REQ_W-1:0]  pass_src;
   logic signed [T:0]        upd_new;
   logic signed [T+1:0]      upd_d;
   logic signed [UPD_W-1:0]  sum_a, sum_b;
   logic [RSP_W-1:0]         payload;

   jtfc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   jtfc_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .res   (mac_res)
   );

   assign k          = ctrl.cnt[AXIS_W-1:0];
   assign req_tready = (ctrl.state == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Operand selection for the shared multiplier. The old and new world
   // images use the transposed matrix.
   always_comb begin
      mac_op.valid = ctrl.issue_valid;
      mac_op.first = ctrl.issue_first;
      mac_op.last  = ctrl.issue_last;
      mac_op.axis  = ctrl.issue_axis;
      coef_row     = ctrl.issue_term;
      coef_col     = ctrl.issue_axis;
      case (ctrl.state)
         ST_FWD: begin
            coef_row = ctrl.issue_axis;
            coef_col = ctrl.issue_term;
            mac_op.a = reqv_ff[ctrl.issue_term];
         end
         ST_NEW: begin
            mac_op.a = {{(REQ_W-T){jnew_ff[ctrl.issue_term][T-1]}}, jnew_ff[ctrl.issue_term]};
         end
         default: begin
            mac_op.a = {{(REQ_W-T){joint_ff[ctrl.issue_term][T-1]}}, joint_ff[ctrl.issue_term]};
         end
      endcase
      mac_op.b = coef_pick(row_ff[coef_row], coef_col);
   end

   // Rounding, clamping and saturation around the multiplier.
   always_comb begin
      rnd_sum = mac_res.acc + RND;
      rnd_val = rnd_sum >>> COEF_FRAC_BITS;
      if (rnd_val > WLD_HI) begin
         wld_val = WLD_HI[T:0];
      end else if (rnd_val < WLD_LO) begin
         wld_val = WLD_LO[T:0];
      end else begin
         wld_val = rnd_val[T:0];
      end

      lim_ext = {{(ACC_W-LIMIT_W){1'b0}}, limit_ff};
      lim_val = (lim_ext < TMAX) ? lim_ext : TMAX;
      if (ctrl.state == ST_LOCAL) begin
         clamp_src  = {{(ACC_W-VEC_W){vec_ff[k][VEC_W-1]}}, vec_ff[k]};
         clamp_axis = k;
         clamp_ev   = 1'b1;
      end else begin
         clamp_src  = rnd_val;
         clamp_axis = mac_res.axis;
         clamp_ev   = (ctrl.state == ST_FWD) && mac_res.valid;
      end
      hit_hi = clamp_src > lim_val;
      hit_lo = clamp_src < -lim_val;
      if (hit_hi) begin
         clamp_res = lim_val;
      end else if (hit_lo) begin
         clamp_res = -lim_val;
      end else begin
         clamp_res = clamp_src;
      end

      // World request of one axis.
      s_vec    = {{(SUM_W-VEC_W){vec_ff[k][VEC_W-1]}}, vec_ff[k]};
      s_wld    = {{(SUM_W-T-1){world_ff[k][T]}}, world_ff[k]};
      s_bone_a = {{(SUM_W-B){bone_a_ff[k][B-1]}}, bone_a_ff[k]};
      s_bone_b = {{(SUM_W-B){bone_b_ff[k][B-1]}}, bone_b_ff[k]};
      case (func_ff)
         FUNC_BONE_A: s_req = s_vec - (s_bone_a - s_wld);
         FUNC_BONE_B: s_req = (s_bone_b + s_wld) - s_vec;
         default:     s_req = s_vec;
      endcase
      s_req_ext = {{(RSAT_W-SUM_W){s_req[SUM_W-1]}}, s_req};
      if (s_req_ext > REQ_HI) begin
         req_sat = REQ_HI[REQ_W-1:0];
      end else if (s_req_ext < REQ_LO) begin
         req_sat = REQ_LO[REQ_W-1:0];
      end else begin
         req_sat = s_req_ext[REQ_W-1:0];
      end

      // An unclamped world request is its own actual torque.
      pass     = (func_ff != FUNC_LOCAL) && !clamped_ff;
      pass_src = reqv_ff[k];
      if (!pass) begin
         upd_new = neww_ff[k];
      end else if (pass_src > PAS_HI) begin
         upd_new = PAS_HI[T:0];
      end else if (pass_src < PAS_LO) begin
         upd_new = PAS_LO[T:0];
      end else begin
         upd_new = pass_src[T:0];
      end
      upd_d = {upd_new[T], upd_new} - {oldw_ff[k][T], oldw_ff[k]};
      sum_a = {{(UPD_W-B){bone_a_ff[k][B-1]}}, bone_a_ff[k]} +
              {{(UPD_W-T-2){upd_d[T+1]}}, upd_d};
      sum_b = {{(UPD_W-B){bone_b_ff[k][B-1]}}, bone_b_ff[k]} -
              {{(UPD_W-T-2){upd_d[T+1]}}, upd_d};

      payload = {change_ff[2], change_ff[1], change_ff[0],
                 world_ff[2], world_ff[1], world_ff[0],
                 jnew_ff[2], jnew_ff[1], jnew_ff[0]};

      stat.start      = req_tvalid && req_tready;
      stat.func_local = (func_ff == FUNC_LOCAL);
      stat.pass_req   = pass && !(clamp_ev && (hit_hi || hit_lo));
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // Next values of all registers.
   always_comb begin
      row_in       = row_ff;
      limit_in     = limit_ff;
      joint_in     = joint_ff;
      world_in     = world_ff;
      bone_a_in    = bone_a_ff;
      bone_b_in    = bone_b_ff;
      func_in      = func_ff;
      vec_in       = vec_ff;
      reqv_in      = reqv_ff;
      jnew_in      = jnew_ff;
      oldw_in      = oldw_ff;
      neww_in      = neww_ff;
      change_in    = change_ff;
      clamped_in   = clamped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_ROW_ZERO: row_in[0] = csr_data;
            CSR_ROW_ONE:  row_in[1] = csr_data;
            CSR_ROW_TWO:  row_in[2] = csr_data;
            CSR_LIMIT:    limit_in  = csr_data[LIMIT_W-1:0];
            default:      limit_in  = limit_ff;
         endcase
      end

      if (stat.start) begin
         func_in    = req_tuser;
         vec_in[0]  = req_tdata[VEC_W-1:0];
         vec_in[1]  = req_tdata[2*VEC_W-1:VEC_W];
         vec_in[2]  = req_tdata[3*VEC_W-1:2*VEC_W];
         clamped_in = 1'b0;
      end

      if (mac_res.valid && (ctrl.state == ST_OLD)) begin
         oldw_in[mac_res.axis] = wld_val;
      end
      if (mac_res.valid && (ctrl.state == ST_NEW)) begin
         neww_in[mac_res.axis] = wld_val;
      end
      if (ctrl.state == ST_REQ) begin
         reqv_in[k] = req_sat;
      end
      if (clamp_ev) begin
         jnew_in[clamp_axis] = clamp_res[T-1:0];
         if (hit_hi || hit_lo) begin
            clamped_in = 1'b1;
         end
      end

      if (ctrl.state == ST_UPD) begin
         world_in[k]  = upd_new;
         change_in[k] = upd_d;
         if (sum_a > BON_HI) begin
            bone_a_in[k] = BON_HI[B-1:0];
         end else if (sum_a < BON_LO) begin
            bone_a_in[k] = BON_LO[B-1:0];
         end else begin
            bone_a_in[k] = sum_a[B-1:0];
         end
         if (sum_b > BON_HI) begin
            bone_b_in[k] = BON_HI[B-1:0];
         end else if (sum_b < BON_LO) begin
            bone_b_in[k] = BON_LO[B-1:0];
         end else begin
            bone_b_in[k] = sum_b[B-1:0];
         end
         if (ctrl.cnt == CNT_W'(AXIS_END)) begin
            joint_in = jnew_ff;
         end
      end

      if ((ctrl.state == ST_OUT) && stat.out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'(payload);
         rsp_user_in  = clamped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]    <= ROW0_RESET;
         row_ff[1]    <= ROW1_RESET;
         row_ff[2]    <= ROW2_RESET;
         limit_ff     <= LIMIT_RESET;
         joint_ff     <= '{default: '0};
         world_ff     <= '{default: '0};
         bone_a_ff    <= '{default: '0};
         bone_b_ff    <= '{default: '0};
         clamped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         limit_ff     <= limit_in;
         joint_ff     <= joint_in;
         world_ff     <= world_in;
         bone_a_ff    <= bone_a_in;
         bone_b_ff    <= bone_b_in;
         clamped_ff   <= clamped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      vec_ff      <= vec_in;
      reqv_ff     <= reqv_in;
      jnew_ff     <= jnew_in;
      oldw_ff     <= oldw_in;
      neww_ff     <= neww_in;
      change_ff   <= change_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `JTFC_ASSERT_IMP(a_mac_in_phase, mac_res.valid, (ctrl.state == ST_OLD || ctrl.state == ST_FWD || ctrl.state == ST_NEW), "multiplier result outside a matrix phase")
   `JTFC_ASSERT_NXT(a_out_load, (ctrl.state == ST_OUT && stat.out_free), (rsp_tvalid && ctrl.state == ST_IDLE), "finished item not handed to the output register")
   `JTFC_ASSERT_IMP(a_rsp_source, $rose(rsp_tvalid), $past(ctrl.state == ST_OUT), "result shown without a finished item")
   `JTFC_ASSERT_NXT(a_start_fresh, stat.start, (ctrl.state == ST_OLD && !clamped_ff), "accepted item did not start with a clear clamp flag")

endmodule

FILE: rtl/jtfc_mac.sv
// ----------------------------------------------------------------------------
// jtfc_mac
// Shared multiply-accumulate unit: a registered product, then an accumulator
// that reports the sum of each three-term dot product.
// ----------------------------------------------------------------------------
module jtfc_mac
   import jtfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  jtfc_mac_op_type  op,
   output jtfc_mac_res_type res
);

   logic                     p_valid_ff, p_valid_in;
   logic                     p_first_ff, p_first_in;
   logic                     p_last_ff, p_last_in;
   logic [AXIS_W-1:0]        p_axis_ff, p_axis_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     r_valid_ff, r_valid_in;
   logic [AXIS_W-1:0]        r_axis_ff, r_axis_in;
   logic signed [ACC_W-1:0]  prod_ext;

   always_comb begin
      p_valid_in = op.valid;
      p_first_in = op.first;
      p_last_in  = op.last;
      p_axis_in  = op.axis;
      prod_in    = $signed(op.a) * $signed(op.b);

      prod_ext   = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      acc_in     = acc_ff;
      if (p_valid_ff) begin
         acc_in = p_first_ff ? prod_ext : acc_ff + prod_ext;
      end
      r_valid_in = p_valid_ff && p_last_ff;
      r_axis_in  = p_axis_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_first_ff <= p_first_in;
      p_last_ff  <= p_last_in;
      p_axis_ff  <= p_axis_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      r_axis_ff  <= r_axis_in;
   end

   assign res.valid = r_valid_ff;
   assign res.axis  = r_axis_ff;
   assign res.acc   = acc_ff;

endmodule

FILE: rtl/jtfc_seq.sv
// ----------------------------------------------------------------------------
// jtfc_seq
// Sequencer of one item: old world image, request and rotation with clamp (or
// local clamp), new world image if needed, totals update, result hand-off.
// ----------------------------------------------------------------------------
module jtfc_seq
   import jtfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  jtfc_stat_type stat,
   output jtfc_ctrl_type ctrl
);

   jtfc_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             mac_phase;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (stat.start) begin
               state_in = ST_OLD;
            end
         end
         ST_OLD: begin
            if (cnt_ff == CNT_W'(MAC_END)) begin
               cnt_in   = '0;
               state_in = stat.func_local ? ST_LOCAL : ST_REQ;
            end
         end
         ST_REQ: begin
            if (cnt_ff == CNT_W'(AXIS_END)) begin
               cnt_in   = '0;
               state_in = ST_FWD;
            end
         end
         ST_LOCAL: begin
            if (cnt_ff == CNT_W'(AXIS_END)) begin
               cnt_in   = '0;
               state_in = ST_NEW;
            end
         end
         ST_FWD: begin
            if (cnt_ff == CNT_W'(MAC_END)) begin
               cnt_in   = '0;
               state_in = stat.pass_req ? ST_UPD : ST_NEW;
            end
         end
         ST_NEW: begin
            if (cnt_ff == CNT_W'(MAC_END)) begin
               cnt_in   = '0;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (cnt_ff == CNT_W'(AXIS_END)) begin
               cnt_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            cnt_in = '0;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = ST_IDLE;
         end
      endcase

      mac_phase        = (state_ff == ST_OLD) || (state_ff == ST_FWD) || (state_ff == ST_NEW);
      ctrl.state       = state_ff;
      ctrl.cnt         = cnt_ff;
      ctrl.issue_valid = mac_phase && (cnt_ff < CNT_W'(MAC_TERMS));
      ctrl.issue_axis  = axis_of(cnt_ff);
      ctrl.issue_term  = term_of(cnt_ff);
      ctrl.issue_first = (term_of(cnt_ff) == '0);
      ctrl.issue_last  = (term_of(cnt_ff) == AXIS_W'(AXIS_END));
   end

endmodule
